// ----- rtl/twc_pkg.sv -----
// Shared codes, constants and tag types for the two-way write-back cache.
package twc_pkg;

  localparam int DEF_NUM_SETS = 128;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;

  localparam logic [2:0] RES_READ  = 3'd0;
  localparam logic [2:0] RES_WACK  = 3'd1;
  localparam logic [2:0] RES_WB    = 3'd2;
  localparam logic [2:0] RES_FREQ  = 3'd3;
  localparam logic [2:0] RES_ERR   = 3'd4;

  localparam int LINE_BYTES = 16;
  localparam int LINE_BITS  = LINE_BYTES * 8;

  typedef struct packed {
    logic [27:0] line;
    logic        dirty;
    logic        valid;
  } tag_t;

  typedef struct packed {
    logic        recent;
    tag_t [1:0]  way;
  } tag_row_t;

  localparam int TAG_ROW_W = $bits(tag_row_t);

endpackage

// ----- rtl/two_way_write_back_cache.sv -----
// Top level of the two-way set-associative write-back cache.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_stall  | kind, address, size, write_data, fill_data
//  result  | out       | out_valid / out_stall| kind_res, mem_address, mem_data, read_data,
//          |           |                      | was_hit, hit_count, access_count, last
//
// One item at a time. An access passes the set index state (set index from the modulo
// unit, by reciprocal multiply unless the set count is a power of two), then the lookup
// state, then its results, up to 3 results on a dirty miss; a fill beat goes straight to lookup.
// After reset a clearing pass writes every tag row with in_stall high. Results
// wait in the result registers while out_stall is high;
// no new item is taken until the last one has transferred.
module two_way_write_back_cache #(
  parameter int NUM_SETS = twc_pkg::DEF_NUM_SETS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] address,
  input  logic [3:0]  size,
  input  logic [63:0] write_data,
  input  logic [63:0] fill_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind_res,
  output logic [31:0] mem_address,
  output logic [63:0] mem_data,
  output logic [63:0] read_data,
  output logic        was_hit,
  output logic [31:0] hit_count,
  output logic [31:0] access_count,
  output logic        last
);
  import twc_pkg::*;

  localparam int SW = $clog2(NUM_SETS);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SET, S_LOOK, S_OUT} state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] maddr;
    logic [63:0] mdata;
    logic [63:0] rdata;
    logic        hit;
    logic        last;
  } res_t;

  state_t state;

  // item registers
  logic [1:0]  it_kind;
  logic [31:0] it_addr;
  logic [3:0]  it_size;
  logic [63:0] it_wdata;
  logic [63:0] it_fdata;
  logic [SW-1:0] set_r;

  // pending miss
  logic          fill_waiting;
  logic          fill_beat;
  logic          pend_way;
  logic [31:0]   pend_addr;
  logic          pend_write;
  logic [3:0]    pend_size;
  logic [63:0]   pend_data;
  logic [SW-1:0] pend_set;
  logic [63:0]   fill_lo;

  logic [31:0] hit_counter;
  logic [31:0] access_counter;

  res_t       res [3];
  logic [1:0] out_idx;
  logic [1:0] out_n;
  logic [SW-1:0] clr_cnt;

  // memories and set unit
  logic            mod_start, mod_done;
  logic [SW-1:0]   mod_rem;
  logic            tag_we, line_we;
  logic [SW-1:0]   tag_waddr, rd_addr;
  tag_row_t        tag_wrow, tag_rrow;
  logic [TAG_ROW_W-1:0] tag_rbits;
  logic [2*LINE_BITS-1:0] line_wrow, line_rrow;

  twc_set_mod #(.NUM_SETS(NUM_SETS)) u_set (
    .clk, .rst, .start(mod_start), .value(address[31:4]),
    .done(mod_done), .rem(mod_rem)
  );

  twc_ram #(.DEPTH(NUM_SETS), .WIDTH(TAG_ROW_W)) u_tag (
    .clk, .we(tag_we), .waddr(tag_waddr), .wdata(tag_wrow),
    .raddr(rd_addr), .rdata(tag_rbits)
  );

  twc_ram #(.DEPTH(NUM_SETS), .WIDTH(2*LINE_BITS)) u_line (
    .clk, .we(line_we), .waddr(set_r), .wdata(line_wrow),
    .raddr(rd_addr), .rdata(line_rrow)
  );

  assign tag_rrow = tag_row_t'(tag_rbits);

  logic in_acc;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign mod_start = in_acc && (kind == KIND_READ || kind == KIND_WRITE) && !fill_waiting;
  // reads issue every cycle: pending set while idle (fill), remainder while indexing
  assign rd_addr   = (state == S_SET) ? mod_rem : pend_set;

  // lookup and completion
  logic          hit0, hit1, hit, hway, victim, is_fill, cway, cwrite;
  logic [27:0]   line_no;
  logic [LINE_BITS-1:0] cline, nline;
  logic [3:0]    coff, csize, cn;
  logic [63:0]   cdata, crdata;
  logic [4:0]    b;
  tag_t          vt;

  always_comb begin
    line_no = it_addr[31:4];
    hit0    = tag_rrow.way[0].valid && tag_rrow.way[0].line == line_no;
    hit1    = tag_rrow.way[1].valid && tag_rrow.way[1].line == line_no;
    hit     = hit0 || hit1;
    hway    = !hit0;
    victim  = !tag_rrow.way[1].valid ? 1'b1 : !tag_rrow.recent;
    vt      = tag_rrow.way[victim];
    is_fill = (it_kind == KIND_FILL);

    cway   = is_fill ? pend_way : hway;
    cwrite = is_fill ? pend_write : (it_kind == KIND_WRITE);
    coff   = is_fill ? pend_addr[3:0] : it_addr[3:0];
    csize  = is_fill ? pend_size : it_size;
    cdata  = is_fill ? pend_data : it_wdata;
    if (is_fill) begin
      cline = {it_fdata, fill_lo};
    end else begin
      cline = hway ? line_rrow[2*LINE_BITS-1:LINE_BITS] : line_rrow[LINE_BITS-1:0];
    end
    cn     = (csize > 4'd8) ? 4'd8 : csize;
    nline  = cline;
    crdata = '0;
    for (int i = 0; i < 8; i++) begin
      b = 5'(coff) + 5'(i);
      // bytes past the line end are dropped
      if (4'(i) < cn && !b[4]) begin
        if (cwrite) begin
          nline[b[3:0]*8 +: 8] = cdata[i*8 +: 8];
        end else begin
          crdata[i*8 +: 8] = cline[b[3:0]*8 +: 8];
        end
      end
    end
    if (cwrite) begin
      crdata = '0;
    end
  end

  // memory writes
  always_comb begin
    tag_we    = 1'b0;
    line_we   = 1'b0;
    tag_waddr = set_r;
    tag_wrow  = tag_rrow;
    line_wrow = line_rrow;
    if (cway) begin
      line_wrow[2*LINE_BITS-1:LINE_BITS] = nline;
    end else begin
      line_wrow[LINE_BITS-1:0] = nline;
    end
    case (state)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_cnt;
        tag_wrow  = '0;
      end
      S_LOOK: begin
        if (is_fill) begin
          if (fill_beat) begin
            tag_we  = 1'b1;
            line_we = 1'b1;
            tag_wrow.recent             = pend_way;
            tag_wrow.way[pend_way].line  = pend_addr[31:4];
            tag_wrow.way[pend_way].valid = 1'b1;
            tag_wrow.way[pend_way].dirty = pend_write;
          end
        end else if (hit) begin
          tag_we  = 1'b1;
          line_we = cwrite;
          tag_wrow.recent = hway;
          if (cwrite) begin
            tag_wrow.way[hway].dirty = 1'b1;
          end
        end else begin
          // victim stays invalid until its refill completes
          tag_we = 1'b1;
          tag_wrow.way[victim] = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      fill_waiting   <= 1'b0;
      fill_beat      <= 1'b0;
      pend_way       <= 1'b0;
      pend_addr      <= '0;
      pend_write     <= 1'b0;
      pend_size      <= '0;
      pend_data      <= '0;
      pend_set       <= '0;
      hit_counter    <= '0;
      access_counter <= '0;
      out_idx        <= '0;
      out_n          <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_cnt == SW'(NUM_SETS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            it_kind  <= kind;
            it_addr  <= address;
            it_size  <= size;
            it_wdata <= write_data;
            it_fdata <= fill_data;
            out_idx  <= '0;
            if (kind == KIND_FILL && fill_waiting) begin
              set_r <= pend_set;
              state <= S_LOOK;
            end else if (mod_start) begin
              state <= S_SET;
            end else begin
              // stray fill beat, unused kind or access during a fill
              res[0] <= '{kind: RES_ERR, maddr: '0, mdata: '0, rdata: '0,
                          hit: 1'b0, last: 1'b1};
              out_n  <= 2'd1;
              state  <= S_OUT;
            end
          end
        end
        S_SET: begin
          if (mod_done) begin
            set_r <= mod_rem;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (is_fill) begin
            if (!fill_beat) begin
              fill_lo   <= it_fdata;
              fill_beat <= 1'b1;
              state     <= S_IDLE;
            end else begin
              fill_beat    <= 1'b0;
              fill_waiting <= 1'b0;
              res[0] <= '{kind: pend_write ? RES_WACK : RES_READ, maddr: '0, mdata: '0,
                          rdata: crdata, hit: 1'b0, last: 1'b1};
              out_n  <= 2'd1;
              state  <= S_OUT;
            end
          end else begin
            if (access_counter != '1) begin
              access_counter <= access_counter + 32'd1;
            end
            if (hit) begin
              if (hit_counter != '1) begin
                hit_counter <= hit_counter + 32'd1;
              end
              res[0] <= '{kind: cwrite ? RES_WACK : RES_READ, maddr: '0, mdata: '0,
                          rdata: crdata, hit: 1'b1, last: 1'b1};
              out_n  <= 2'd1;
            end else begin
              if (vt.valid && vt.dirty) begin
                res[0] <= '{kind: RES_WB, maddr: {vt.line, 4'h0},
                            mdata: victim ? line_rrow[LINE_BITS+63:LINE_BITS]
                                          : line_rrow[63:0],
                            rdata: '0, hit: 1'b0, last: 1'b0};
                res[1] <= '{kind: RES_WB, maddr: {vt.line, 4'h8},
                            mdata: victim ? line_rrow[2*LINE_BITS-1:LINE_BITS+64]
                                          : line_rrow[LINE_BITS-1:64],
                            rdata: '0, hit: 1'b0, last: 1'b0};
                res[2] <= '{kind: RES_FREQ, maddr: {line_no, 4'h0}, mdata: '0,
                            rdata: '0, hit: 1'b0, last: 1'b1};
                out_n  <= 2'd3;
              end else begin
                res[0] <= '{kind: RES_FREQ, maddr: {line_no, 4'h0}, mdata: '0,
                            rdata: '0, hit: 1'b0, last: 1'b1};
                out_n  <= 2'd1;
              end
              fill_waiting <= 1'b1;
              fill_beat    <= 1'b0;
              pend_way     <= victim;
              pend_addr    <= it_addr;
              pend_write   <= (it_kind == KIND_WRITE);
              pend_size    <= it_size;
              pend_data    <= it_wdata;
              pend_set     <= set_r;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (out_idx == out_n - 2'd1) begin
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign kind_res     = res[out_idx].kind;
  assign mem_address  = res[out_idx].maddr;
  assign mem_data     = res[out_idx].mdata;
  assign read_data    = res[out_idx].rdata;
  assign was_hit      = res[out_idx].hit;
  assign last         = res[out_idx].last;
  assign hit_count    = hit_counter;
  assign access_count = access_counter;
endmodule

// ----- rtl/twc_ram.sv -----
// Synchronous single-port-write, single-port-read memory with registered read.
module twc_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/twc_set_mod.sv -----
// Set index unit: line number modulo the set count, by reciprocal multiplication (low bits for a power-of-two count).
module twc_set_mod #(
  parameter int NUM_SETS = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [27:0]                   value,
  output logic                          done,
  output logic [$clog2(NUM_SETS)-1:0]   rem
);
  localparam int SW = $clog2(NUM_SETS);
  localparam int KSH = 28 + SW;
  localparam bit IS_POW2 = (NUM_SETS == (1 << SW));
  localparam logic [SW:0] N_W = (SW+1)'(NUM_SETS);
  localparam logic [27:0] N_L = 28'(NUM_SETS);
  // floor(2^KSH / NUM_SETS): the quotient estimate is exact or one short
  localparam logic [28:0] RECIP = 29'((64'd1 << KSH) / 64'(NUM_SETS));

  logic [27:0]   x;
  logic [27:0]   q;
  logic [56:0]   prod;
  logic [SW:0]   rr;
  logic [SW-1:0] r;
  logic          busy1;
  logic          busy2;

  assign prod = 57'(value) * 57'(RECIP);
  assign rem  = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy1 <= 1'b0;
      busy2 <= 1'b0;
      done  <= 1'b0;
    end else if (start) begin
      x     <= value;
      q     <= 28'(prod >> KSH);
      busy2 <= 1'b0;
      if (IS_POW2) begin
        r     <= value[SW-1:0];
        done  <= 1'b1;
        busy1 <= 1'b0;
      end else begin
        done  <= 1'b0;
        busy1 <= 1'b1;
      end
    end else begin
      busy1 <= 1'b0;
      busy2 <= busy1;
      if (busy1) begin
        // below twice the set count
        rr <= (SW+1)'(x - q * N_L);
      end
      if (busy2) begin
        if (rr >= N_W) begin
          r <= SW'(rr - N_W);
        end else begin
          r <= rr[SW-1:0];
        end
        done <= 1'b1;
      end
    end
  end
endmodule
